### hdl/rtes_pkg.sv
// Shared types, widths and constants for the rigid transform extent score block.
package rtes_pkg;

    localparam int FRAC_BITS = 16;

    // Field and register widths
    localparam int CFG_W    = 17;  // Q1.16 parameter register
    localparam int CFG_IDX_W = 3;
    localparam int PT_W     = 24;  // Q8.16 point coordinate
    localparam int Q_W      = 19;  // quaternion component 2p-1
    localparam int ENT_W    = 18;  // rotation entry, signed, in [-1,1]
    localparam int SMUL_W   = Q_W + PT_W;
    localparam int PROD_W   = 38;  // products of quaternion components
    localparam int NUM_W    = 40;  // matrix numerators
    localparam int LEN_W    = 38;  // squared quaternion length
    localparam int QUO_W    = 18;
    localparam int ACC_W    = 44;  // rotation dot product
    localparam int SH_W     = 22;  // shift (p-0.5)*10
    localparam int T_W      = 29;  // transformed coordinate
    localparam int AX_W     = 25;  // smoothed maximum
    localparam int V_W      = 33;  // 99*max + |t| + 50
    localparam int UOP_W    = 34;
    localparam int UPROD_W  = 2 * UOP_W;
    localparam int SCORE_W  = 43;
    localparam int OUT_TDATA_W = 48;
    localparam int IN_TDATA_W  = 3 * PT_W;

    localparam int N_CFG  = 7;
    localparam int N_ENT  = 9;
    localparam int N_SQ   = 10;
    localparam int N_AX   = 3;
    localparam int DIV_STEPS = FRAC_BITS;
    localparam int STEP_W = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] CFG_ONE  = CFG_W'(1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] CFG_HALF = CFG_W'(1 << (FRAC_BITS - 1));

    // floor(v/100) = (v * RECIP_100) >> RECIP_SHIFT, exact for v below 2^32
    localparam logic [31:0] RECIP_100  = 32'd2748779070;
    localparam int          RECIP_SHIFT = 38;
    localparam int          QDIV_W      = 30;

    localparam logic [AX_W-1:0]    AXIS_MAX  = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // Configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W   = 3'd0,
        REG_QUAT_X   = 3'd1,
        REG_QUAT_Y   = 3'd2,
        REG_QUAT_Z   = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6
    } cfg_reg_t;

    // Quaternion component products, in the order they are formed
    typedef enum logic [3:0] {
        SQ_AA = 4'd0, SQ_BB = 4'd1, SQ_CC = 4'd2, SQ_DD = 4'd3, SQ_BC = 4'd4,
        SQ_AD = 4'd5, SQ_BD = 4'd6, SQ_AC = 4'd7, SQ_CD = 4'd8, SQ_AB = 4'd9
    } sq_t;

    // Row-major matrix entry positions
    localparam logic [3:0] ENT_00 = 4'd0, ENT_01 = 4'd1, ENT_02 = 4'd2;
    localparam logic [3:0] ENT_10 = 4'd3, ENT_11 = 4'd4, ENT_12 = 4'd5;
    localparam logic [3:0] ENT_20 = 4'd6, ENT_21 = 4'd7, ENT_22 = 4'd8;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        UM_RECIP = 2'd0,
        UM_M01   = 2'd1,
        UM_P12M2 = 2'd2
    } umul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_LEN, ST_LCHK, ST_DLOAD, ST_DIV, ST_DFIN,
        ST_ROT, ST_RACC, ST_AX_EVAL, ST_AX_MUL, ST_AX_WR,
        ST_SC_M01, ST_SC_M2, ST_OUT
    } state_t;

    typedef struct packed {
        logic      load_point;
        logic      clr_max;
        logic      sq_mul;
        logic      len_calc;
        logic      len_chk;
        logic      div_load;
        logic      div_step;
        logic      div_fin;
        logic [3:0] idx;
        logic      rot_mul;
        logic [1:0] row;
        logic [1:0] col;
        acc_op_t   acc_op;
        logic      ax_eval;
        logic      ax_write;
        logic      ax_first;
        logic      umul_en;
        umul_sel_t umul_sel;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic last;
    } sts_t;

endpackage

### hdl/rigid_transform_extent_score_core.sv
// Top level of the rigid transform extent score block.
//
//  channel   direction  transaction         payload
//  s_        in         one point           tdata {z,y,x} Q8.16, tlast = last point
//  m_        out        one score per cloud tdata extent_score Q27.16, tuser degenerate
//  cfg_      in         one register write  cfg_index, cfg_data (17 bits, Q1.16)
//
//  Sequence: a point that opens a cloud first forms ten products on one 19x24
//  multiplier, then runs nine bit-serial divides for the matrix; with a zero
//  quaternion the divides are skipped. Every point then runs three rows of
//  seven steps, each row three rotation products on the signed multiplier and
//  a divide by 100 on a second unsigned multiplier. A last point adds the
//  score products and the output step.
//  Reset: aresetn, synchronous, active low; restores register defaults and
//  marks the next point as opening a cloud.
//  Stalls: a held score does not block the input; the block only waits in its
//  final step if the previous score has not yet been taken.
module rigid_transform_extent_score_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input points
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rtes_pkg::IN_TDATA_W-1:0]     s_tdata,   // point_x, point_y, point_z
    input  logic                                s_tlast,   // last_point
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rtes_pkg::OUT_TDATA_W-1:0]    m_tdata,   // extent_score, zero pad
    output logic                                m_tuser,   // degenerate
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rtes_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtes_pkg::CFG_W-1:0]          cfg_data
);

    rtes_pkg::cmd_t              cmd;
    rtes_pkg::sts_t              sts;
    logic [rtes_pkg::SCORE_W-1:0] score;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    rtes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtes_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pt_data    (s_tdata),
        .pt_last    (s_tlast),
        .cmd        (cmd),
        .sts        (sts),
        .score      (score),
        .degenerate (m_tuser)
    );

    // Pad the score to whole bytes
    assign m_tdata = {{(rtes_pkg::OUT_TDATA_W - rtes_pkg::SCORE_W){1'b0}}, score};

endmodule

### hdl/rtes_ctrl.sv
// Sequencer for the extent score block: issues datapath commands per step.
module rtes_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  rtes_pkg::sts_t   sts,
    output rtes_pkg::cmd_t   cmd
);

    rtes_pkg::state_t               state_reg, state_next;
    logic [3:0]                     idx_reg, idx_next;
    logic [rtes_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [1:0]                     row_reg, row_next;
    logic [1:0]                     col_reg, col_next;
    logic                           first_reg, first_next;
    logic                           cur_first_reg, cur_first_next;
    logic                           m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rtes_pkg::ST_IDLE;
            idx_reg       <= '0;
            step_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            first_reg     <= 1'b1;
            cur_first_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            first_reg     <= first_next;
            cur_first_reg <= cur_first_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        first_next     = first_reg;
        cur_first_next = cur_first_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.idx        = idx_reg;
        cmd.row        = row_reg;
        cmd.col        = col_reg;
        cmd.acc_op     = rtes_pkg::ACC_HOLD;
        cmd.umul_sel   = rtes_pkg::UM_RECIP;
        cmd.ax_first   = cur_first_reg;

        case (state_reg)
            rtes_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_point = 1'b1;
                    cur_first_next = first_reg;
                    first_next     = 1'b0;
                    row_next       = '0;
                    col_next       = '0;
                    idx_next       = '0;
                    if (first_reg) begin
                        cmd.clr_max = 1'b1;
                        state_next  = rtes_pkg::ST_SQ;
                    end else begin
                        state_next  = rtes_pkg::ST_ROT;
                    end
                end
            end
            rtes_pkg::ST_SQ: begin
                cmd.sq_mul = 1'b1;
                if (idx_reg == 4'(rtes_pkg::N_SQ - 1)) begin
                    state_next = rtes_pkg::ST_LEN;
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            rtes_pkg::ST_LEN: begin
                cmd.len_calc = 1'b1;
                state_next   = rtes_pkg::ST_LCHK;
            end
            rtes_pkg::ST_LCHK: begin
                cmd.len_chk = 1'b1;
                idx_next    = '0;
                if (sts.len_zero) begin
                    state_next = rtes_pkg::ST_ROT;
                end else begin
                    state_next = rtes_pkg::ST_DLOAD;
                end
            end
            rtes_pkg::ST_DLOAD: begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = rtes_pkg::ST_DIV;
            end
            rtes_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == rtes_pkg::STEP_W'(rtes_pkg::DIV_STEPS - 1)) begin
                    state_next = rtes_pkg::ST_DFIN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            rtes_pkg::ST_DFIN: begin
                cmd.div_fin = 1'b1;
                if (idx_reg == 4'(rtes_pkg::N_ENT - 1)) begin
                    state_next = rtes_pkg::ST_ROT;
                end else begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = rtes_pkg::ST_DLOAD;
                end
            end
            rtes_pkg::ST_ROT: begin
                cmd.rot_mul = 1'b1;
                case (col_reg)
                    2'd0:    cmd.acc_op = rtes_pkg::ACC_HOLD;
                    2'd1:    cmd.acc_op = rtes_pkg::ACC_LOAD;
                    default: cmd.acc_op = rtes_pkg::ACC_ADD;
                endcase
                if (col_reg == 2'd2) begin
                    state_next = rtes_pkg::ST_RACC;
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            rtes_pkg::ST_RACC: begin
                cmd.acc_op = rtes_pkg::ACC_ADD;
                state_next = rtes_pkg::ST_AX_EVAL;
            end
            rtes_pkg::ST_AX_EVAL: begin
                cmd.ax_eval = 1'b1;
                state_next  = rtes_pkg::ST_AX_MUL;
            end
            rtes_pkg::ST_AX_MUL: begin
                cmd.umul_en  = 1'b1;
                cmd.umul_sel = rtes_pkg::UM_RECIP;
                state_next   = rtes_pkg::ST_AX_WR;
            end
            rtes_pkg::ST_AX_WR: begin
                cmd.ax_write = 1'b1;
                col_next     = '0;
                if (row_reg == 2'd2) begin
                    if (sts.last) begin
                        state_next = rtes_pkg::ST_SC_M01;
                    end else begin
                        state_next = rtes_pkg::ST_IDLE;
                    end
                end else begin
                    row_next   = row_reg + 2'd1;
                    state_next = rtes_pkg::ST_ROT;
                end
            end
            rtes_pkg::ST_SC_M01: begin
                cmd.umul_en  = 1'b1;
                cmd.umul_sel = rtes_pkg::UM_M01;
                state_next   = rtes_pkg::ST_SC_M2;
            end
            rtes_pkg::ST_SC_M2: begin
                cmd.umul_en  = 1'b1;
                cmd.umul_sel = rtes_pkg::UM_P12M2;
                state_next   = rtes_pkg::ST_OUT;
            end
            rtes_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    first_next   = 1'b1;
                    state_next   = rtes_pkg::ST_IDLE;
                end
            end
            default: state_next = rtes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

### hdl/rtes_dp.sv
// Datapath: parameter registers, matrix build, rotation, maxima and score.
module rtes_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [rtes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtes_pkg::CFG_W-1:0]        cfg_data,
    input  logic [rtes_pkg::IN_TDATA_W-1:0]   pt_data,
    input  logic                              pt_last,
    input  rtes_pkg::cmd_t                    cmd,
    output rtes_pkg::sts_t                    sts,
    output logic [rtes_pkg::SCORE_W-1:0]      score,
    output logic                              degenerate
);

    localparam int PW = rtes_pkg::PT_W;
    localparam int NW = rtes_pkg::NUM_W;

    logic [rtes_pkg::CFG_W-1:0]          cfg_reg   [rtes_pkg::N_CFG];
    logic signed [PW-1:0]                pt_reg    [3];
    logic                                last_reg;
    logic signed [rtes_pkg::PROD_W-1:0]  prod_reg  [rtes_pkg::N_SQ];
    logic [rtes_pkg::LEN_W-1:0]          len_reg;
    logic                                zero_reg;
    logic signed [rtes_pkg::ENT_W-1:0]   ent_reg   [rtes_pkg::N_ENT];
    logic [NW-1:0]                       rem_reg;
    logic [rtes_pkg::QUO_W-1:0]          quo_reg;
    logic                                neg_reg;
    logic signed [rtes_pkg::SMUL_W-1:0]  mul_reg;
    logic signed [rtes_pkg::ACC_W-1:0]   acc_reg;
    logic [rtes_pkg::AX_W-1:0]           mag_reg;
    logic [rtes_pkg::V_W-1:0]            v_reg;
    logic [rtes_pkg::UPROD_W-1:0]        umul_reg;
    logic [rtes_pkg::AX_W-1:0]           max_reg   [rtes_pkg::N_AX];
    logic [rtes_pkg::SCORE_W-1:0]        score_reg;
    logic                                degen_reg;

    // Quaternion components 2p - 1
    logic signed [rtes_pkg::Q_W-1:0] qa, qb, qc, qd;
    assign qa = $signed({1'b0, cfg_reg[rtes_pkg::REG_QUAT_W], 1'b0})
              - $signed({2'b0, rtes_pkg::CFG_ONE});
    assign qb = $signed({1'b0, cfg_reg[rtes_pkg::REG_QUAT_X], 1'b0})
              - $signed({2'b0, rtes_pkg::CFG_ONE});
    assign qc = $signed({1'b0, cfg_reg[rtes_pkg::REG_QUAT_Y], 1'b0})
              - $signed({2'b0, rtes_pkg::CFG_ONE});
    assign qd = $signed({1'b0, cfg_reg[rtes_pkg::REG_QUAT_Z], 1'b0})
              - $signed({2'b0, rtes_pkg::CFG_ONE});

    // Signed multiplier shared by the product pass and the rotation
    logic [3:0]                          ent_idx;
    logic signed [rtes_pkg::Q_W-1:0]     sa;
    logic signed [PW-1:0]                sb;
    logic signed [rtes_pkg::SMUL_W-1:0]  smul;

    assign ent_idx = {1'b0, cmd.row, 1'b0} + {2'b0, cmd.row} + {2'b0, cmd.col};

    always_comb begin
        sa = qa;
        sb = PW'(qa);
        if (cmd.rot_mul) begin
            sa = rtes_pkg::Q_W'(ent_reg[ent_idx]);
            case (cmd.col)
                2'd0:    sb = pt_reg[0];
                2'd1:    sb = pt_reg[1];
                default: sb = pt_reg[2];
            endcase
        end else begin
            case (rtes_pkg::sq_t'(cmd.idx))
                rtes_pkg::SQ_AA: begin sa = qa; sb = PW'(qa); end
                rtes_pkg::SQ_BB: begin sa = qb; sb = PW'(qb); end
                rtes_pkg::SQ_CC: begin sa = qc; sb = PW'(qc); end
                rtes_pkg::SQ_DD: begin sa = qd; sb = PW'(qd); end
                rtes_pkg::SQ_BC: begin sa = qb; sb = PW'(qc); end
                rtes_pkg::SQ_AD: begin sa = qa; sb = PW'(qd); end
                rtes_pkg::SQ_BD: begin sa = qb; sb = PW'(qd); end
                rtes_pkg::SQ_AC: begin sa = qa; sb = PW'(qc); end
                rtes_pkg::SQ_CD: begin sa = qc; sb = PW'(qd); end
                rtes_pkg::SQ_AB: begin sa = qa; sb = PW'(qb); end
                default:         begin sa = qa; sb = PW'(qa); end
            endcase
        end
    end

    assign smul = rtes_pkg::SMUL_W'(sa) * rtes_pkg::SMUL_W'(sb);

    // Matrix numerators from the stored products
    logic signed [NW-1:0] paa, pbb, pcc, pdd, pbc, pad, pbd, pac, pcd, pab;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        num_mag, den, mag_sub, rem_dbl;

    assign paa = NW'(prod_reg[rtes_pkg::SQ_AA]);
    assign pbb = NW'(prod_reg[rtes_pkg::SQ_BB]);
    assign pcc = NW'(prod_reg[rtes_pkg::SQ_CC]);
    assign pdd = NW'(prod_reg[rtes_pkg::SQ_DD]);
    assign pbc = NW'(prod_reg[rtes_pkg::SQ_BC]);
    assign pad = NW'(prod_reg[rtes_pkg::SQ_AD]);
    assign pbd = NW'(prod_reg[rtes_pkg::SQ_BD]);
    assign pac = NW'(prod_reg[rtes_pkg::SQ_AC]);
    assign pcd = NW'(prod_reg[rtes_pkg::SQ_CD]);
    assign pab = NW'(prod_reg[rtes_pkg::SQ_AB]);

    always_comb begin
        case (cmd.idx)
            rtes_pkg::ENT_00: num = paa + pbb - pcc - pdd;
            rtes_pkg::ENT_01: num = (pbc + pad) <<< 1;
            rtes_pkg::ENT_02: num = (pbd - pac) <<< 1;
            rtes_pkg::ENT_10: num = (pbc - pad) <<< 1;
            rtes_pkg::ENT_11: num = paa - pbb + pcc - pdd;
            rtes_pkg::ENT_12: num = (pcd + pab) <<< 1;
            rtes_pkg::ENT_20: num = (pbd + pac) <<< 1;
            rtes_pkg::ENT_21: num = (pcd - pab) <<< 1;
            rtes_pkg::ENT_22: num = paa - pbb - pcc + pdd;
            default:          num = '0;
        endcase
    end

    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign den     = NW'(len_reg);
    assign mag_sub = num_mag - den;
    assign rem_dbl = {rem_reg[NW-2:0], 1'b0};

    // Rounded, clamped quotient
    logic [rtes_pkg::QUO_W-1:0] quo_rnd, quo_clamp;
    assign quo_rnd   = quo_reg + ((rem_dbl >= den) ? rtes_pkg::QUO_W'(1) : '0);
    assign quo_clamp = (quo_rnd > rtes_pkg::QUO_W'(rtes_pkg::CFG_ONE))
                     ? rtes_pkg::QUO_W'(rtes_pkg::CFG_ONE) : quo_rnd;

    // Transformed coordinate of the current row
    logic [rtes_pkg::CFG_W-1:0]            off_raw;
    logic signed [rtes_pkg::CFG_W:0]       off_d;
    logic signed [rtes_pkg::SH_W-1:0]      shift_v;
    logic signed [rtes_pkg::ACC_W-1:0]     acc_rnd;
    logic signed [rtes_pkg::T_W-1:0]       t_val;
    logic [rtes_pkg::T_W-1:0]              t_mag;
    logic [rtes_pkg::AX_W-1:0]             t_sat, max_row;

    always_comb begin
        case (cmd.row)
            2'd0:    off_raw = cfg_reg[rtes_pkg::REG_OFFSET_X];
            2'd1:    off_raw = cfg_reg[rtes_pkg::REG_OFFSET_Y];
            default: off_raw = cfg_reg[rtes_pkg::REG_OFFSET_Z];
        endcase
        case (cmd.row)
            2'd0:    max_row = max_reg[0];
            2'd1:    max_row = max_reg[1];
            default: max_row = max_reg[2];
        endcase
    end

    assign off_d   = $signed({1'b0, off_raw}) - $signed({1'b0, rtes_pkg::CFG_HALF});
    assign shift_v = (rtes_pkg::SH_W'(off_d) <<< 3) + (rtes_pkg::SH_W'(off_d) <<< 1);
    assign acc_rnd = acc_reg + rtes_pkg::ACC_W'(rtes_pkg::CFG_HALF);
    assign t_val   = rtes_pkg::T_W'(acc_rnd >>> rtes_pkg::FRAC_BITS)
                   + rtes_pkg::T_W'(shift_v);
    assign t_mag   = t_val[rtes_pkg::T_W-1] ? rtes_pkg::T_W'(-t_val) : rtes_pkg::T_W'(t_val);
    assign t_sat   = (t_mag > rtes_pkg::T_W'(rtes_pkg::AXIS_MAX))
                   ? rtes_pkg::AXIS_MAX : t_mag[rtes_pkg::AX_W-1:0];

    // 99*max as shift-add
    logic [rtes_pkg::V_W-1:0] m99;
    assign m99 = (rtes_pkg::V_W'(max_row) << 6) + (rtes_pkg::V_W'(max_row) << 5)
               + (rtes_pkg::V_W'(max_row) << 1) + rtes_pkg::V_W'(max_row);

    // Unsigned multiplier: divide by 100 and the score product
    logic [rtes_pkg::UOP_W-1:0]   ua, ub, p12;
    logic [rtes_pkg::UPROD_W-1:0] umul_rnd;
    logic [rtes_pkg::QDIV_W-1:0]  q100;
    logic [rtes_pkg::AX_W-1:0]    q_sat;
    logic [rtes_pkg::UPROD_W-rtes_pkg::FRAC_BITS-1:0] score_full;

    assign umul_rnd = umul_reg + rtes_pkg::UPROD_W'(rtes_pkg::CFG_HALF);
    assign p12      = umul_rnd[rtes_pkg::FRAC_BITS +: rtes_pkg::UOP_W];

    always_comb begin
        case (cmd.umul_sel)
            rtes_pkg::UM_M01: begin
                ua = rtes_pkg::UOP_W'(max_reg[0]);
                ub = rtes_pkg::UOP_W'(max_reg[1]);
            end
            rtes_pkg::UM_P12M2: begin
                ua = p12;
                ub = rtes_pkg::UOP_W'(max_reg[2]);
            end
            default: begin
                ua = rtes_pkg::UOP_W'(v_reg);
                ub = rtes_pkg::UOP_W'(rtes_pkg::RECIP_100);
            end
        endcase
    end

    assign q100       = umul_reg[rtes_pkg::RECIP_SHIFT +: rtes_pkg::QDIV_W];
    assign q_sat      = (q100 > rtes_pkg::QDIV_W'(rtes_pkg::AXIS_MAX))
                      ? rtes_pkg::AXIS_MAX : q100[rtes_pkg::AX_W-1:0];
    assign score_full = umul_rnd[rtes_pkg::UPROD_W-1:rtes_pkg::FRAC_BITS];

    // Control-bearing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[rtes_pkg::REG_QUAT_W]   <= rtes_pkg::CFG_ONE;
            cfg_reg[rtes_pkg::REG_QUAT_X]   <= rtes_pkg::CFG_HALF;
            cfg_reg[rtes_pkg::REG_QUAT_Y]   <= rtes_pkg::CFG_HALF;
            cfg_reg[rtes_pkg::REG_QUAT_Z]   <= rtes_pkg::CFG_HALF;
            cfg_reg[rtes_pkg::REG_OFFSET_X] <= rtes_pkg::CFG_HALF;
            cfg_reg[rtes_pkg::REG_OFFSET_Y] <= rtes_pkg::CFG_HALF;
            cfg_reg[rtes_pkg::REG_OFFSET_Z] <= rtes_pkg::CFG_HALF;
            zero_reg <= 1'b0;
            for (int i = 0; i < rtes_pkg::N_AX; i++) max_reg[i] <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    rtes_pkg::REG_QUAT_W:   cfg_reg[rtes_pkg::REG_QUAT_W]   <= cfg_data;
                    rtes_pkg::REG_QUAT_X:   cfg_reg[rtes_pkg::REG_QUAT_X]   <= cfg_data;
                    rtes_pkg::REG_QUAT_Y:   cfg_reg[rtes_pkg::REG_QUAT_Y]   <= cfg_data;
                    rtes_pkg::REG_QUAT_Z:   cfg_reg[rtes_pkg::REG_QUAT_Z]   <= cfg_data;
                    rtes_pkg::REG_OFFSET_X: cfg_reg[rtes_pkg::REG_OFFSET_X] <= cfg_data;
                    rtes_pkg::REG_OFFSET_Y: cfg_reg[rtes_pkg::REG_OFFSET_Y] <= cfg_data;
                    rtes_pkg::REG_OFFSET_Z: cfg_reg[rtes_pkg::REG_OFFSET_Z] <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.len_chk) zero_reg <= (len_reg == '0);
            if (cmd.clr_max) begin
                for (int i = 0; i < rtes_pkg::N_AX; i++) max_reg[i] <= '0;
            end else if (cmd.ax_write && (cmd.ax_first || (mag_reg > max_row))) begin
                max_reg[cmd.row] <= q_sat;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            pt_reg[0] <= pt_data[0 +: PW];
            pt_reg[1] <= pt_data[PW +: PW];
            pt_reg[2] <= pt_data[2*PW +: PW];
            last_reg  <= pt_last;
        end
        if (cmd.sq_mul) prod_reg[cmd.idx] <= rtes_pkg::PROD_W'(smul);
        if (cmd.len_calc) begin
            len_reg <= rtes_pkg::LEN_W'(paa + pbb + pcc + pdd);
        end
        if (cmd.len_chk && (len_reg == '0)) begin
            for (int i = 0; i < rtes_pkg::N_ENT; i++) ent_reg[i] <= '0;
        end
        if (cmd.div_load) begin
            neg_reg <= num[NW-1];
            if (num_mag >= den) begin
                quo_reg <= rtes_pkg::QUO_W'(1);
                rem_reg <= (mag_sub >= den) ? '0 : mag_sub;
            end else begin
                quo_reg <= '0;
                rem_reg <= num_mag;
            end
        end
        if (cmd.div_step) begin
            if (rem_dbl >= den) begin
                rem_reg <= rem_dbl - den;
                quo_reg <= {quo_reg[rtes_pkg::QUO_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_dbl;
                quo_reg <= {quo_reg[rtes_pkg::QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.div_fin) begin
            ent_reg[cmd.idx] <= neg_reg ? -$signed(quo_clamp) : $signed(quo_clamp);
        end
        if (cmd.rot_mul) mul_reg <= smul;
        case (cmd.acc_op)
            rtes_pkg::ACC_LOAD: acc_reg <= rtes_pkg::ACC_W'(mul_reg);
            rtes_pkg::ACC_ADD:  acc_reg <= acc_reg + rtes_pkg::ACC_W'(mul_reg);
            default: ;
        endcase
        if (cmd.ax_eval) begin
            mag_reg <= t_sat;
            v_reg   <= m99 + rtes_pkg::V_W'(t_sat) + rtes_pkg::V_W'(50);
        end
        if (cmd.umul_en) umul_reg <= rtes_pkg::UPROD_W'(ua) * rtes_pkg::UPROD_W'(ub);
        if (cmd.out_load) begin
            degen_reg <= zero_reg;
            if (zero_reg) begin
                score_reg <= '0;
            end else if (score_full > (rtes_pkg::UPROD_W - rtes_pkg::FRAC_BITS)'(
                                          rtes_pkg::SCORE_MAX)) begin
                score_reg <= rtes_pkg::SCORE_MAX;
            end else begin
                score_reg <= score_full[rtes_pkg::SCORE_W-1:0];
            end
        end
    end

    assign sts.len_zero = (len_reg == '0);
    assign sts.last     = last_reg;
    assign score        = score_reg;
    assign degenerate   = degen_reg;

endmodule

### hdl/rtes_chk.sv
// Port-level checks for the extent score block, bound to the top level.
module rtes_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rtes_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result with non-zero score");

    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result raised by a point that is not last");

endmodule

bind rigid_transform_extent_score_core rtes_chk u_rtes_chk (.*);
